/* hdl/arpm_pkg.sv */
// Shared types, constants and request byte table for the ARP resolver.
package arpm_pkg;

  localparam int unsigned FRAME_LEN   = 42;
  localparam int unsigned OFF_W       = 6;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_ADDR_W  = 5;

  // input opcodes
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RX   = 1'b1;

  // result kinds
  localparam logic KIND_TX       = 1'b0;
  localparam logic KIND_RESOLVED = 1'b1;

  // register indexes (paddr[4:3])
  localparam logic [1:0] REG_LOCAL_MAC = 2'd0;
  localparam logic [1:0] REG_LOCAL_IP  = 2'd1;
  localparam logic [1:0] REG_TARGET_IP = 2'd2;

  // frame offsets
  localparam logic [OFF_W-1:0] OFF_LEN     = OFF_W'(FRAME_LEN);
  localparam logic [OFF_W-1:0] OFF_LAST    = OFF_W'(FRAME_LEN - 1);
  localparam logic [OFF_W-1:0] OFF_TYPE_HI = 6'd12;
  localparam logic [OFF_W-1:0] OFF_TYPE_LO = 6'd13;
  localparam logic [OFF_W-1:0] OFF_OPER_HI = 6'd20;
  localparam logic [OFF_W-1:0] OFF_OPER_LO = 6'd21;
  localparam logic [OFF_W-1:0] OFF_SHA0    = 6'd22;
  localparam logic [OFF_W-1:0] OFF_SHA5    = 6'd27;
  localparam logic [OFF_W-1:0] OFF_SPA0    = 6'd28;
  localparam logic [OFF_W-1:0] OFF_SPA1    = 6'd29;
  localparam logic [OFF_W-1:0] OFF_SPA2    = 6'd30;
  localparam logic [OFF_W-1:0] OFF_SPA3    = 6'd31;

  typedef struct packed {
    logic [MAC_W-1:0] local_mac;
    logic [IP_W-1:0]  local_ip;
    logic [IP_W-1:0]  target_ip;
  } cfg_t;

  // queue entry: send a request, or report a resolved MAC
  typedef struct packed {
    logic             kind;
    logic [MAC_W-1:0] mac;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] request_byte(input logic [OFF_W-1:0] i, input cfg_t c);
    logic [7:0] b;
    case (i)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: b = 8'hFF;
      6'd6, 6'd22: b = c.local_mac[47:40];
      6'd7, 6'd23: b = c.local_mac[39:32];
      6'd8, 6'd24: b = c.local_mac[31:24];
      6'd9, 6'd25: b = c.local_mac[23:16];
      6'd10, 6'd26: b = c.local_mac[15:8];
      6'd11, 6'd27: b = c.local_mac[7:0];
      6'd12: b = 8'h08;
      6'd13: b = 8'h06;
      6'd14: b = 8'h00;
      6'd15: b = 8'h01;
      6'd16: b = 8'h08;
      6'd17: b = 8'h00;
      6'd18: b = 8'h06;
      6'd19: b = 8'h04;
      6'd20: b = 8'h00;
      6'd21: b = 8'h01;
      6'd28: b = c.local_ip[31:24];
      6'd29: b = c.local_ip[23:16];
      6'd30: b = c.local_ip[15:8];
      6'd31: b = c.local_ip[7:0];
      6'd38: b = c.target_ip[31:24];
      6'd39: b = c.target_ip[23:16];
      6'd40: b = c.target_ip[15:8];
      6'd41: b = c.target_ip[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hdl/arpm_fifo.sv */
// Short command queue between the parser front end and the emitter back end.
module arpm_fifo #(
  parameter int unsigned DEPTH = arpm_pkg::FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  arpm_pkg::qent_t     push_data_i,
  input  logic                pop_i,
  output arpm_pkg::qent_t     head_o,
  output arpm_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  arpm_pkg::qent_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_MAX);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/arpm_front.sv */
// Front end: accepts words, parses received frames, queues send and resolve commands.
module arpm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   opcode_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   rx_last_i,
  input  logic [arpm_pkg::IP_W-1:0] target_ip_i,
  input  arpm_pkg::fifo_stat_t   stat_i,
  output logic                   push_o,
  output arpm_pkg::qent_t        push_data_o
);

  logic [arpm_pkg::OFF_W-1:0] off_q, off_d, off_n;
  logic type_ok_q, type_ok_d, type_n;
  logic reply_ok_q, reply_ok_d, reply_n;
  logic sip_ok_q, sip_ok_d, sip_n;
  logic [arpm_pkg::MAC_W-1:0] mac_q, mac_d, mac_n;
  logic wait_q, wait_d;
  logic accept, hit;

  assign in_ready_o = !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // per-byte field checks
  always_comb begin
    off_n   = off_q;
    type_n  = type_ok_q;
    reply_n = reply_ok_q;
    sip_n   = sip_ok_q;
    mac_n   = mac_q;
    if (off_q < arpm_pkg::OFF_LEN) begin
      off_n = off_q + 1'b1;
      case (off_q)
        arpm_pkg::OFF_TYPE_HI: type_n  = (rx_byte_i == 8'h08);
        arpm_pkg::OFF_TYPE_LO: type_n  = type_ok_q && (rx_byte_i == 8'h06);
        arpm_pkg::OFF_OPER_HI: reply_n = (rx_byte_i == 8'h00);
        arpm_pkg::OFF_OPER_LO: reply_n = reply_ok_q && (rx_byte_i == 8'h02);
        arpm_pkg::OFF_SPA0: sip_n = (rx_byte_i == target_ip_i[31:24]);
        arpm_pkg::OFF_SPA1: sip_n = sip_ok_q && (rx_byte_i == target_ip_i[23:16]);
        arpm_pkg::OFF_SPA2: sip_n = sip_ok_q && (rx_byte_i == target_ip_i[15:8]);
        arpm_pkg::OFF_SPA3: sip_n = sip_ok_q && (rx_byte_i == target_ip_i[7:0]);
        default: begin
          if (off_q >= arpm_pkg::OFF_SHA0 && off_q <= arpm_pkg::OFF_SHA5) begin
            mac_n = {mac_q[arpm_pkg::MAC_W-9:0], rx_byte_i};
          end
        end
      endcase
    end
  end

  assign hit = wait_q && (off_n == arpm_pkg::OFF_LEN) && type_n && reply_n && sip_n;

  always_comb begin
    off_d            = off_q;
    type_ok_d        = type_ok_q;
    reply_ok_d       = reply_ok_q;
    sip_ok_d         = sip_ok_q;
    mac_d            = mac_q;
    wait_d           = wait_q;
    push_o           = 1'b0;
    push_data_o.kind = arpm_pkg::KIND_TX;
    push_data_o.mac  = mac_n;
    if (accept) begin
      if (opcode_i == arpm_pkg::OP_SEND || rx_last_i) begin
        off_d      = '0;
        type_ok_d  = 1'b0;
        reply_ok_d = 1'b0;
        sip_ok_d   = 1'b0;
        mac_d      = '0;
      end else begin
        off_d      = off_n;
        type_ok_d  = type_n;
        reply_ok_d = reply_n;
        sip_ok_d   = sip_n;
        mac_d      = mac_n;
      end
      if (opcode_i == arpm_pkg::OP_SEND) begin
        wait_d = 1'b1;
        push_o = 1'b1;
      end else if (rx_last_i && hit) begin
        wait_d           = 1'b0;
        push_o           = 1'b1;
        push_data_o.kind = arpm_pkg::KIND_RESOLVED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      type_ok_q  <= 1'b0;
      reply_ok_q <= 1'b0;
      sip_ok_q   <= 1'b0;
      mac_q      <= '0;
      wait_q     <= 1'b0;
    end else begin
      off_q      <= off_d;
      type_ok_q  <= type_ok_d;
      reply_ok_q <= reply_ok_d;
      sip_ok_q   <= sip_ok_d;
      mac_q      <= mac_d;
      wait_q     <= wait_d;
    end
  end

endmodule

/* hdl/arpm_back.sv */
// Back end: drains the queue, emits request bytes and resolve words into the output register.
module arpm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  arpm_pkg::cfg_t              cfg_i,
  input  arpm_pkg::qent_t             head_i,
  input  arpm_pkg::fifo_stat_t        stat_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic [7:0]                  tx_byte_o,
  output logic                        tx_last_o,
  output logic [arpm_pkg::MAC_W-1:0]  resolved_mac_o
);

  logic [arpm_pkg::OFF_W-1:0] idx_q, idx_d;
  logic active_q, active_d;
  logic valid_q, valid_d;
  logic kind_q, kind_d, last_q, last_d;
  logic [7:0] byte_q, byte_d;
  logic [arpm_pkg::MAC_W-1:0] mac_q, mac_d;
  logic load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    idx_d    = idx_q;
    active_d = active_q;
    valid_d  = valid_q;
    kind_d   = kind_q;
    last_d   = last_q;
    byte_d   = byte_q;
    mac_d    = mac_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = 1'b0;
      if (active_q) begin
        valid_d = 1'b1;
        kind_d  = arpm_pkg::KIND_TX;
        byte_d  = arpm_pkg::request_byte(idx_q, cfg_i);
        last_d  = (idx_q == arpm_pkg::OFF_LAST);
        mac_d   = '0;
        idx_d   = idx_q + 1'b1;
        if (idx_q == arpm_pkg::OFF_LAST) begin
          active_d = 1'b0;
        end
      end else if (!stat_i.empty) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        kind_d  = head_i.kind;
        last_d  = 1'b0;
        if (head_i.kind == arpm_pkg::KIND_RESOLVED) begin
          byte_d = 8'h00;
          mac_d  = head_i.mac;
        end else begin
          // first request byte goes out now, the rest follow from the counter
          byte_d   = arpm_pkg::request_byte('0, cfg_i);
          mac_d    = '0;
          idx_d    = arpm_pkg::OFF_W'(1);
          active_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    last_q <= last_d;
    byte_q <= byte_d;
    mac_q  <= mac_d;
  end

  assign out_valid_o    = valid_q;
  assign result_kind_o  = kind_q;
  assign tx_byte_o      = byte_q;
  assign tx_last_o      = last_q;
  assign resolved_mac_o = mac_q;

endmodule

/* hdl/arp_request_and_reply_match.sv */
// Top level of the ARP resolver: register port, parser front end, queue, emitter back end.
// An accepted word is first written into the queue; the back end then loads its first
//   result from the queue into the output register, which drives the output handshake.
// Throughput: one input word per cycle; a send yields 42 words at one per cycle from the
//   back end's byte counter, while the front end keeps parsing into a QUEUE_DEPTH queue.
// Input stalls only when the queue is full; the output register holds a word under stall.
// Reset (rst_ni low, async): registers, parse state, queue and output valid all clear.
module arp_request_and_reply_match #(
  parameter int unsigned QUEUE_DEPTH = arpm_pkg::FIFO_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              rx_last_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              result_kind_o,
  output logic [7:0]                        tx_byte_o,
  output logic                              tx_last_o,
  output logic [arpm_pkg::MAC_W-1:0]        resolved_mac_o,
  // register port, registers at 8-byte strides
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [arpm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [arpm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [arpm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  arpm_pkg::cfg_t       cfg_q;
  arpm_pkg::qent_t      push_data, head;
  arpm_pkg::fifo_stat_t stat;
  logic                 push, pop;
  logic                 cfg_wr;
  logic [1:0]           reg_idx;

  // register file; the user must write it only while the datapath is idle, the block itself does not enforce it
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        arpm_pkg::REG_LOCAL_MAC: cfg_q.local_mac <= pwdata[arpm_pkg::MAC_W-1:0];
        arpm_pkg::REG_LOCAL_IP:  cfg_q.local_ip  <= pwdata[arpm_pkg::IP_W-1:0];
        arpm_pkg::REG_TARGET_IP: cfg_q.target_ip <= pwdata[arpm_pkg::IP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      arpm_pkg::REG_LOCAL_MAC: prdata = arpm_pkg::CFG_DATA_W'(cfg_q.local_mac);
      arpm_pkg::REG_LOCAL_IP:  prdata = arpm_pkg::CFG_DATA_W'(cfg_q.local_ip);
      arpm_pkg::REG_TARGET_IP: prdata = arpm_pkg::CFG_DATA_W'(cfg_q.target_ip);
      default:                 prdata = '0;
    endcase
  end

  // front end: frame parse and waiting flag, queues send / resolve commands
  arpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .rx_byte_i   (rx_byte_i),
    .rx_last_i   (rx_last_i),
    .target_ip_i (cfg_q.target_ip),
    .stat_i      (stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  arpm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (stat)
  );

  // back end: 42-byte request sequencer and output register
  arpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head),
    .stat_i         (stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .tx_byte_o      (tx_byte_o),
    .tx_last_o      (tx_last_o),
    .resolved_mac_o (resolved_mac_o)
  );

endmodule

/* verif/arp_request_and_reply_match_test.sv */
// Self-checking testbench for the ARP request/reply resolver: predictor, stimulus and checker.
`timescale 1ns / 1ps

module arp_request_and_reply_match_test;

  // One output word as the checker sees it.
  typedef struct packed {
    logic                       kind;
    logic [7:0]                 tx_byte;
    logic                       tx_last;
    logic [arpm_pkg::MAC_W-1:0] mac;
  } arp_word_t;

  localparam int unsigned FRAME_BITS    = 8 * arpm_pkg::FRAME_LEN;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 16;

  // Wire constants of an Ethernet/IPv4 ARP frame.
  localparam logic [47:0] BCAST_MAC        = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ETH_TYPE_ARP     = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ARP_HTYPE_ETH    = 16'h0001;
  localparam logic [7:0]  ARP_HLEN_ETH     = 8'h06;
  localparam logic [7:0]  ARP_PLEN_IPV4    = 8'h04;
  localparam logic [15:0] ARP_OPER_REQUEST = 16'h0001;
  localparam logic [15:0] ARP_OPER_REPLY   = 16'h0002;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic                            opcode_i;
  logic [7:0]                      rx_byte_i;
  logic                            rx_last_i;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            result_kind_o;
  logic [7:0]                      tx_byte_o;
  logic                            tx_last_o;
  logic [arpm_pkg::MAC_W-1:0]      resolved_mac_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [arpm_pkg::CFG_ADDR_W-1:0] paddr;
  logic [arpm_pkg::CFG_DATA_W-1:0] pwdata;
  logic [arpm_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  arp_request_and_reply_match u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .rx_byte_i      (rx_byte_i),
    .rx_last_i      (rx_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .tx_byte_o      (tx_byte_o),
    .tx_last_o      (tx_last_o),
    .resolved_mac_o (resolved_mac_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Mirror of the register file and of the receive parser.
  arpm_pkg::cfg_t             cfg_mirror = '0;
  int                         rx_seen;
  logic                       type_match;
  logic                       reply_match;
  logic                       spa_match;
  logic [arpm_pkg::MAC_W-1:0] sender_mac;
  logic                       awaiting_reply;

  arp_word_t pending_words[$];

  int send_idle_pct = 37;
  int recv_idle_pct = 53;
  int error_count   = 0;
  int items_sent    = 0;
  int tx_words_seen = 0;
  int resolved_seen = 0;
  int cfg_settings  = 0;
  int cycle_count   = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL arp_request_and_reply_match");
      $finish;
    end
  end

  // Receiver back-pressure, one draw per cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  function automatic logic [7:0] byte_at(input logic [FRAME_BITS-1:0] img, input int idx);
    return img[FRAME_BITS-1-8*idx -: 8];
  endfunction

  // Broadcast request as it goes on the wire, MSB byte first.
  function automatic logic [FRAME_BITS-1:0] request_image();
    return {BCAST_MAC, cfg_mirror.local_mac, ETH_TYPE_ARP, ARP_HTYPE_ETH, ETH_TYPE_IPV4,
            ARP_HLEN_ETH, ARP_PLEN_IPV4, ARP_OPER_REQUEST, cfg_mirror.local_mac,
            cfg_mirror.local_ip, 48'h0, cfg_mirror.target_ip};
  endfunction

  function automatic void clear_parse();
    rx_seen     = 0;
    type_match  = 1'b0;
    reply_match = 1'b0;
    spa_match   = 1'b0;
    sender_mac  = '0;
  endfunction

  function automatic void predict_word(input logic op, input logic [7:0] b, input logic last);
    logic [FRAME_BITS-1:0] req;
    arp_word_t             w;
    logic                  hit;
    if (op == arpm_pkg::OP_SEND) begin
      req = request_image();
      for (int i = 0; i < arpm_pkg::FRAME_LEN; i++) begin
        w = '{kind: arpm_pkg::KIND_TX, tx_byte: byte_at(req, i),
              tx_last: (i == arpm_pkg::FRAME_LEN - 1), mac: '0};
        pending_words.push_back(w);
      end
      clear_parse();
      awaiting_reply = 1'b1;
    end else begin
      // bytes past the ARP payload are dropped, offset saturates
      if (rx_seen < arpm_pkg::FRAME_LEN) begin
        if (rx_seen == arpm_pkg::OFF_TYPE_HI) begin
          type_match = (b == ETH_TYPE_ARP[15:8]);
        end else if (rx_seen == arpm_pkg::OFF_TYPE_LO) begin
          type_match = type_match && (b == ETH_TYPE_ARP[7:0]);
        end else if (rx_seen == arpm_pkg::OFF_OPER_HI) begin
          reply_match = (b == ARP_OPER_REPLY[15:8]);
        end else if (rx_seen == arpm_pkg::OFF_OPER_LO) begin
          reply_match = reply_match && (b == ARP_OPER_REPLY[7:0]);
        end else if (rx_seen >= arpm_pkg::OFF_SHA0 && rx_seen <= arpm_pkg::OFF_SHA5) begin
          sender_mac = {sender_mac[arpm_pkg::MAC_W-9:0], b};
        end else if (rx_seen >= arpm_pkg::OFF_SPA0 && rx_seen <= arpm_pkg::OFF_SPA3) begin
          spa_match = (rx_seen == arpm_pkg::OFF_SPA0 || spa_match) &&
                      (b == cfg_mirror.target_ip[31 - 8*(rx_seen - arpm_pkg::OFF_SPA0) -: 8]);
        end
        rx_seen++;
      end
      if (last) begin
        hit = awaiting_reply && rx_seen == arpm_pkg::FRAME_LEN && type_match &&
              reply_match && spa_match;
        if (hit) begin
          w = '{kind: arpm_pkg::KIND_RESOLVED, tx_byte: 8'h00, tx_last: 1'b0,
                mac: sender_mac};
          pending_words.push_back(w);
          awaiting_reply = 1'b0;
        end
        clear_parse();
      end
    end
  endfunction

  // ------------------------------------------------------------------
  // Checker
  // ------------------------------------------------------------------

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_words
    arp_word_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected word, expected none, got kind %0d byte %0h last %0d mac %0h",
                 $time, result_kind_o, tx_byte_o, tx_last_o, resolved_mac_o);
      end else begin
        due = pending_words.pop_front();
        check_field("result_kind", due.kind, result_kind_o);
        check_field("tx_byte", due.tx_byte, tx_byte_o);
        check_field("tx_last", due.tx_last, tx_last_o);
        check_field("resolved_mac", due.mac, resolved_mac_o);
        if (due.kind == arpm_pkg::KIND_TX) tx_words_seen++;
        else resolved_seen++;
      end
    end
  end

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------

  // Offer one input word, with random idle cycles ahead of it; predict on acceptance.
  task automatic send_word(input logic op, input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    rx_byte_i  <= b;
    rx_last_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    predict_word(op, b, last);
  endtask

  // Byte and last fields are don't-care on a send; keep them moving anyway.
  task automatic send_request();
    send_word(arpm_pkg::OP_SEND, 8'($urandom), 1'($urandom));
  endtask

  // Frame bytes from an image; past the image end the bytes are random padding.
  task automatic send_frame(input logic [FRAME_BITS-1:0] img, input int len, input logic close);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (i < arpm_pkg::FRAME_LEN) ? byte_at(img, i) : 8'($urandom);
      send_word(arpm_pkg::OP_RX, b, close && (i == len - 1));
    end
  endtask

  // Stop offering words and let every expected word drain, then let the pipe settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(input logic [1:0] idx,
                           input logic [arpm_pkg::CFG_DATA_W-1:0] value);
    logic [arpm_pkg::CFG_DATA_W-1:0] mask;
    mask = (idx == arpm_pkg::REG_LOCAL_MAC)
         ? {{(arpm_pkg::CFG_DATA_W-arpm_pkg::MAC_W){1'b0}}, {arpm_pkg::MAC_W{1'b1}}}
         : {{(arpm_pkg::CFG_DATA_W-arpm_pkg::IP_W){1'b0}}, {arpm_pkg::IP_W{1'b1}}};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      arpm_pkg::REG_LOCAL_MAC: cfg_mirror.local_mac = value[arpm_pkg::MAC_W-1:0];
      arpm_pkg::REG_LOCAL_IP:  cfg_mirror.local_ip  = value[arpm_pkg::IP_W-1:0];
      default:                 cfg_mirror.target_ip = value[arpm_pkg::IP_W-1:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    check_field("prdata", value & mask, prdata & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [arpm_pkg::MAC_W-1:0] mac,
                            input logic [arpm_pkg::IP_W-1:0] own_ip,
                            input logic [arpm_pkg::IP_W-1:0] tgt_ip);
    wait_drained();
    write_reg(arpm_pkg::REG_LOCAL_MAC, arpm_pkg::CFG_DATA_W'(mac));
    write_reg(arpm_pkg::REG_LOCAL_IP, arpm_pkg::CFG_DATA_W'(own_ip));
    write_reg(arpm_pkg::REG_TARGET_IP, arpm_pkg::CFG_DATA_W'(tgt_ip));
    cfg_settings++;
  endtask

  // ------------------------------------------------------------------
  // Frame builders
  // ------------------------------------------------------------------

  function automatic logic [arpm_pkg::MAC_W-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // ARP reply addressed to us, from sha/spa.
  function automatic logic [FRAME_BITS-1:0] reply_image(
      input logic [arpm_pkg::MAC_W-1:0] sha, input logic [arpm_pkg::IP_W-1:0] spa);
    return {cfg_mirror.local_mac, sha, ETH_TYPE_ARP, ARP_HTYPE_ETH, ETH_TYPE_IPV4,
            ARP_HLEN_ETH, ARP_PLEN_IPV4, ARP_OPER_REPLY, sha, spa, cfg_mirror.local_mac,
            cfg_mirror.local_ip};
  endfunction

  // Corrupt one of the fields the matcher looks at: ethertype, ARP operation or sender IP.
  function automatic logic [FRAME_BITS-1:0] spoil_reply(input logic [FRAME_BITS-1:0] img);
    int         o;
    logic [7:0] flip;
    case ($urandom_range(3))
      0:       o = $urandom_range(arpm_pkg::OFF_TYPE_LO, arpm_pkg::OFF_TYPE_HI);
      1:       o = $urandom_range(arpm_pkg::OFF_OPER_LO, arpm_pkg::OFF_OPER_HI);
      default: o = $urandom_range(arpm_pkg::OFF_SPA3, arpm_pkg::OFF_SPA0);
    endcase
    flip = 8'($urandom_range(255, 1));
    img[FRAME_BITS-1-8*o -: 8] = img[FRAME_BITS-1-8*o -: 8] ^ flip;
    return img;
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Reply with nothing outstanding: parsed, never reported. Runs on reset config.
  task automatic test_unsolicited_reply();
    send_frame(reply_image(random_mac(), cfg_mirror.target_ip), arpm_pkg::FRAME_LEN, 1'b1);
  endtask

  // Full request on extreme settings; sender holds off until all 42 words are out.
  task automatic test_request_frame();
    set_config({arpm_pkg::MAC_W{1'b1}}, '0, {arpm_pkg::IP_W{1'b1}});
    send_request();
    wait_drained();
  endtask

  // One byte short of a full ARP frame: must not resolve.
  task automatic test_short_reply();
    send_frame(reply_image('0, cfg_mirror.target_ip), arpm_pkg::FRAME_LEN - 1, 1'b1);
  endtask

  // Send in the middle of a frame drops it; back-to-back sends; then a clean reply resolves.
  task automatic test_restart_on_send();
    send_frame(reply_image(random_mac(), cfg_mirror.target_ip), 12, 1'b0);
    send_request();
    send_request();
    send_frame(reply_image({arpm_pkg::MAC_W{1'b1}}, cfg_mirror.target_ip),
               arpm_pkg::FRAME_LEN, 1'b1);
  endtask

  // Opposite extremes, and an all-zero sender MAC as the answer.
  task automatic test_swapped_extremes();
    set_config('0, {arpm_pkg::IP_W{1'b1}}, '0);
    send_request();
    send_frame(reply_image('0, cfg_mirror.target_ip), arpm_pkg::FRAME_LEN, 1'b1);
  endtask

  // Full reply with a bad ethertype, operation or sender IP: no match, still waiting.
  task automatic test_spoiled_reply();
    send_request();
    send_frame(spoil_reply(reply_image(random_mac(), cfg_mirror.target_ip)),
               arpm_pkg::FRAME_LEN, 1'b1);
  endtask

  // Trailing bytes after the ARP payload do not spoil a match.
  task automatic test_long_reply();
    send_request();
    send_frame(reply_image(random_mac(), cfg_mirror.target_ip), arpm_pkg::FRAME_LEN + 4,
               1'b1);
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin
    in_valid_i <= 1'b0;
    opcode_i   <= arpm_pkg::OP_RX;
    rx_byte_i  <= 8'h00;
    rx_last_i  <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    rst_ni     <= 1'b0;
    clear_parse();
    awaiting_reply = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles 37%, receiver 53%
    test_unsolicited_reply();
    test_request_frame();
    test_short_reply();
    test_restart_on_send();

    // the other way round
    send_idle_pct = 53;
    recv_idle_pct = 37;
    test_swapped_extremes();

    // no idling on either side
    set_config(random_mac(), $urandom, $urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_spoiled_reply();
    test_long_reply();

    wait_drained();
    $display("run: %0d input words over %0d register settings", items_sent, cfg_settings);
    $display("run: %0d request bytes and %0d resolved addresses checked",
             tx_words_seen, resolved_seen);
    if (error_count == 0) begin
      $display("PASS arp_request_and_reply_match");
    end else begin
      $display("FAIL arp_request_and_reply_match");
    end
    $finish;
  end

endmodule
